// ===== rtl/core/vector_norm_engine_unit_defines.svh =====
// assertion macros for the vector norm engine
// used by vector_norm_engine_unit; expects clk and rst_n in the including scope
`ifndef VECTOR_NORM_ENGINE_UNIT_DEFINES_SVH
`define VECTOR_NORM_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define VNE_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vne: same-cycle check failed");

`define VNE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vne: next-cycle check failed");

`else

`define VNE_ASSERT_IMPLY(name, ante, cons)

`define VNE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/core/vne_pkg.sv =====
// types and constants shared by the vector norm engine
// no dependencies
package vne_pkg;

    localparam int MAG_W      = 16;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 49;
    localparam int COUNT_W    = 17;
    localparam int ROOT_W     = 25;
    localparam int ROOT_STEPS = 25;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

    localparam logic [SUM_W-1:0] SUM_CAP = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [15:0] a_value;
        logic signed [15:0] b_value;
        logic               last;
    } vne_in_t;

    typedef struct packed {
        logic [24:0] two_norm;
        logic [15:0] max_norm;
        logic [16:0] element_count;
        logic        overflowed;
    } vne_out_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_ROOT,
        ST_EMIT
    } vne_state_t;

    typedef struct packed {
        logic take;
        logic step;
        logic emit;
    } vne_cmd_t;

    typedef struct packed {
        logic s1_valid;
        logic s1_last;
        logic out_busy;
    } vne_stat_t;

endpackage

// ===== rtl/core/vne_ctrl.sv =====
// controller for the vector norm engine: request gating, root step count, result write
// depends on vne_pkg
module vne_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vne_pkg::vne_stat_t    stat,
    output vne_pkg::vne_cmd_t     cmd,
    output vne_pkg::vne_state_t   state
);

    localparam int SW = vne_pkg::STEP_W;

    vne_pkg::vne_state_t state_reg;
    vne_pkg::vne_state_t state_next;
    logic [SW-1:0]       step_cnt_reg;
    logic [SW-1:0]       step_cnt_next;
    logic                last_in_flight;

    assign last_in_flight = stat.s1_valid && stat.s1_last;
    assign state          = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vne_pkg::ST_RUN;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = '0;
        case (state_reg)
            vne_pkg::ST_RUN:
            begin
                if (last_in_flight)
                begin
                    state_next = vne_pkg::ST_ROOT;
                end
            end
            vne_pkg::ST_ROOT:
            begin
                step_cnt_next = step_cnt_reg + SW'(1);
                if (step_cnt_reg == SW'(vne_pkg::ROOT_STEPS - 1))
                begin
                    state_next    = vne_pkg::ST_EMIT;
                    step_cnt_next = '0;
                end
            end
            vne_pkg::ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = vne_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = vne_pkg::ST_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            vne_pkg::ST_RUN:
            begin
                in_ready = !last_in_flight;
                cmd.take = in_valid && !last_in_flight;
            end
            vne_pkg::ST_ROOT:
            begin
                cmd.step = 1'b1;
            end
            vne_pkg::ST_EMIT:
            begin
                cmd.emit = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/vne_dp.sv =====
// datapath for the vector norm engine: square stage, accumulators, bitwise root, result register
// depends on vne_pkg
module vne_dp
#(
    parameter logic [vne_pkg::COUNT_W-1:0] COUNT_CAP = 17'd65536
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  vne_pkg::vne_in_t   in_data,
    input  logic               out_ready,
    output logic               out_valid,
    output vne_pkg::vne_out_t  out_data,
    input  vne_pkg::vne_cmd_t  cmd,
    output vne_pkg::vne_stat_t stat
);

    localparam int MW = vne_pkg::MAG_W;
    localparam int QW = vne_pkg::SQ_W;
    localparam int SW = vne_pkg::SUM_W;
    localparam int CW = vne_pkg::COUNT_W;
    localparam int RW = vne_pkg::ROOT_W;

    logic mode_reg;

    // stage 1: magnitude and square
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [MW-1:0]     s1_mag_reg;
    logic [QW-1:0]     s1_sq_reg;
    logic signed [MW:0] a_ext;
    logic signed [MW:0] b_ext;
    logic signed [MW:0] elem;
    logic [MW:0]       mag_wide;
    logic [MW-1:0]     mag;
    logic [QW-1:0]     sq;

    // stage 2: accumulators
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [MW-1:0] max_reg;
    logic [MW-1:0] max_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          sat_reg;
    logic          sat_next;
    logic [SW-1:0] sum_upd;
    logic [MW-1:0] max_upd;
    logic [CW-1:0] count_upd;
    logic          sat_upd;
    logic [SW:0]   sum_try;

    // root unit
    logic [SW-1:0] rt_x_reg;
    logic [SW-1:0] rt_x_next;
    logic [SW-1:0] rt_res_reg;
    logic [SW-1:0] rt_res_next;
    logic [SW-1:0] rt_bit_reg;
    logic [SW-1:0] rt_bit_next;
    logic [MW-1:0] rt_max_reg;
    logic [CW-1:0] rt_count_reg;
    logic          rt_sat_reg;
    logic [SW:0]   rt_trial;
    logic          load_root;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    vne_pkg::vne_out_t    out_reg;

    assign a_ext    = {in_data.a_value[MW-1], in_data.a_value};
    assign b_ext    = {in_data.b_value[MW-1], in_data.b_value};
    assign elem     = mode_reg ? (a_ext - b_ext) : a_ext;
    assign mag_wide = elem[MW] ? (MW+1)'(-elem) : elem;
    assign mag      = mag_wide[MW-1:0];
    assign sq       = QW'(mag * mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            s1_valid_reg <= cmd.take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            s1_last_reg <= in_data.last;
            s1_mag_reg  <= mag;
            s1_sq_reg   <= sq;
        end
    end

    // element update
    always_comb
    begin
        max_upd = (s1_mag_reg > max_reg) ? s1_mag_reg : max_reg;
        sum_try = {1'b0, sum_reg} + (SW+1)'(s1_sq_reg);
        if (count_reg >= COUNT_CAP)
        begin
            count_upd = count_reg;
            sat_upd   = 1'b1;
            sum_upd   = vne_pkg::SUM_CAP;
        end
        else
        begin
            count_upd = count_reg + CW'(1);
            if (sat_reg || (sum_try > {1'b0, vne_pkg::SUM_CAP}))
            begin
                sat_upd = 1'b1;
                sum_upd = vne_pkg::SUM_CAP;
            end
            else
            begin
                sat_upd = 1'b0;
                sum_upd = sum_try[SW-1:0];
            end
        end
    end

    assign load_root = s1_valid_reg && s1_last_reg;

    always_comb
    begin
        sum_next   = sum_reg;
        max_next   = max_reg;
        count_next = count_reg;
        sat_next   = sat_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                sum_next   = '0;
                max_next   = '0;
                count_next = '0;
                sat_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_upd;
                max_next   = max_upd;
                count_next = count_upd;
                sat_next   = sat_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            max_reg   <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            count_reg <= count_next;
            sat_reg   <= sat_next;
        end
    end

    // one result bit per step
    always_comb
    begin
        rt_trial    = {1'b0, rt_res_reg} + {1'b0, rt_bit_reg};
        rt_x_next   = rt_x_reg;
        rt_res_next = rt_res_reg;
        rt_bit_next = rt_bit_reg;
        if (load_root)
        begin
            rt_x_next   = sum_upd;
            rt_res_next = '0;
            rt_bit_next = vne_pkg::SUM_CAP;
        end
        else if (cmd.step)
        begin
            if ({1'b0, rt_x_reg} >= rt_trial)
            begin
                rt_x_next   = rt_x_reg - rt_trial[SW-1:0];
                rt_res_next = (rt_res_reg >> 1) + rt_bit_reg;
            end
            else
            begin
                rt_res_next = rt_res_reg >> 1;
            end
            rt_bit_next = rt_bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        rt_x_reg   <= rt_x_next;
        rt_res_reg <= rt_res_next;
        rt_bit_reg <= rt_bit_next;
        if (load_root)
        begin
            rt_max_reg   <= max_upd;
            rt_count_reg <= count_upd;
            rt_sat_reg   <= sat_upd;
        end
    end

    // result register
    assign out_valid_next = cmd.emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.two_norm      <= rt_res_reg[RW-1:0];
            out_reg.max_norm      <= rt_max_reg;
            out_reg.element_count <= rt_count_reg;
            out_reg.overflowed    <= rt_sat_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s1_last  = s1_last_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

endmodule

// ===== rtl/core/vector_norm_engine_unit.sv =====
// top level of the vector norm engine: 2-norm and max norm of a streamed vector
// depends on vne_pkg, vne_ctrl, vne_dp and vector_norm_engine_unit_defines.svh
//
//   channel   handshake                 payload
//   in        in_valid / in_ready       in_data  (vne_in_t)
//   out       out_valid / out_ready     out_data (vne_out_t)
//   cfg       cfg_write_en              cfg_write_data (difference mode)
//
// elements are taken one request per cycle while in_ready is high; square and accumulate run as a two-stage pipe
// the last element stops input through the pipe drain, the root steps (one root bit per cycle
// over the 49-bit sum) and the result register write
// input also stalls while the next result waits for a busy output register
// reset clears all accumulators, the mode register and both valid flags
`include "vector_norm_engine_unit_defines.svh"

module vector_norm_engine_unit
#(
    parameter int unsigned MAX_LENGTH = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vne_pkg::vne_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vne_pkg::vne_out_t out_data,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data
);

    localparam int CW = vne_pkg::COUNT_W;
    localparam int unsigned CAP_INT = (MAX_LENGTH < vne_pkg::COUNT_MAX) ?
                                      MAX_LENGTH : vne_pkg::COUNT_MAX;
    localparam logic [CW-1:0] COUNT_CAP = CW'(CAP_INT);

    vne_pkg::vne_cmd_t   cmd;
    vne_pkg::vne_stat_t  stat;
    vne_pkg::vne_state_t state;

    vne_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    vne_dp
    #(
        .COUNT_CAP (COUNT_CAP)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_data        (in_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_data       (out_data),
        .cmd            (cmd),
        .stat           (stat)
    );

    // no request taken while the root unit works
    `VNE_ASSERT_IMPLY(a_no_take_in_root, state == vne_pkg::ST_ROOT, !in_ready)
    // a last element in the pipe starts the root
    `VNE_ASSERT_NEXT(a_last_starts_root, stat.s1_valid && stat.s1_last, state == vne_pkg::ST_ROOT)
    // a result write never overruns a waiting result
    `VNE_ASSERT_IMPLY(a_emit_slot_free, cmd.emit, !out_valid || out_ready)

endmodule
